>>> rtl/core/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types, constants and the byte-wide crc-16 step for the escaped frame
// receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CNT_MIN_W = $clog2(MAX_FRAME + 1);
  // counter never narrower than the reported length field
  localparam int unsigned CNT_W     = (CNT_MIN_W > LEN_W) ? CNT_MIN_W : LEN_W;

  localparam logic [7:0]  ESC_BYTE  = 8'hE5;
  localparam logic [15:0] CRC16_GEN = 16'h1021;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_FLAG = 2'd1,
    MODE_DATA = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_DROP    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic [7:0]        frame_flag;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

  // msb-first crc-16, polynomial 0x1021, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC16_GEN;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/efr_in_reg.sv
// ----------------------------------------------------------------------------
// efr_in_reg
// Input register: captures one received byte and holds it until the decode
// stage can move it on.
// ----------------------------------------------------------------------------
module efr_in_reg import efr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

>>> rtl/core/efr_decode.sv
// ----------------------------------------------------------------------------
// efr_decode
// Unstuffing, frame state, two-byte delay and crc. Updates its state and
// forms at most one result for each byte it consumes.
// ----------------------------------------------------------------------------
module efr_decode import efr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       consume,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  logic             esc_r,   esc_nxt;
  mode_t            mode_r,  mode_nxt;
  logic [7:0]       flag_r,  flag_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       near_r,  near_nxt;
  logic [7:0]       far_r,   far_nxt;
  logic [1:0]       prime_r, prime_nxt;
  logic [15:0]      crc_r,   crc_nxt;

  logic             is_esc;
  logic             boundary;
  logic             opening;
  logic             closing;
  logic [7:0]       c_eff;
  mode_t            mode_pre;
  logic [1:0]       prime_pre;
  logic [15:0]      crc_pre;
  logic [CNT_W-1:0] count_pre;
  logic [CNT_W-1:0] count_inc;
  logic             active;
  logic             emit_slot;
  logic             overflow;

  assign is_esc    = (rx_byte == ESC_BYTE);
  assign boundary  = !is_esc && esc_r && (rx_byte != 8'h00);
  assign opening   = boundary && rx_byte[7];
  assign closing   = boundary && (mode_r != MODE_NONE);
  assign c_eff     = (esc_r && rx_byte == 8'h00) ? ESC_BYTE : rx_byte;

  // state as seen after the boundary handling
  assign mode_pre  = boundary ? (opening ? MODE_FLAG : MODE_NONE) : mode_r;
  assign prime_pre = opening ? 2'd2 : prime_r;
  assign crc_pre   = opening ? 16'h0000 : crc_r;
  assign count_pre = opening ? '0 : count_r;
  assign count_inc = count_pre + CNT_W'(1);

  assign active    = !is_esc && (mode_pre != MODE_NONE);
  assign emit_slot = active && (prime_pre == 2'd0) && (mode_pre == MODE_DATA);
  assign overflow  = emit_slot && (count_pre >= CNT_W'(MAX_FRAME));

  // next frame mode
  always_comb begin
    priority if (is_esc) begin
      mode_nxt = mode_r;
    end else if (!active || prime_pre != 2'd0) begin
      mode_nxt = mode_pre;
    end else if (mode_pre == MODE_FLAG) begin
      mode_nxt = MODE_DATA;
    end else if (overflow) begin
      mode_nxt = MODE_NONE;
    end else begin
      mode_nxt = MODE_DATA;
    end
  end

  // datapath next values
  always_comb begin
    esc_nxt   = is_esc;
    flag_nxt  = opening ? rx_byte : flag_r;
    count_nxt = (emit_slot && !overflow) ? count_inc : count_pre;
    prime_nxt = (active && prime_pre != 2'd0) ? prime_pre - 2'd1 : prime_pre;
    crc_nxt   = active ? crc_byte(crc_pre, c_eff) : crc_pre;
    near_nxt  = active ? c_eff : near_r;
    far_nxt   = active ? near_r : far_r;
  end

  // result
  always_comb begin
    res_valid        = closing || emit_slot;
    res.kind         = KIND_PAYLOAD;
    res.data         = 8'h00;
    res.frame_flag   = flag_r;
    res.frame_length = count_pre[LEN_W-1:0];
    priority if (closing) begin
      res.kind         = (crc_r == 16'h0000) ? KIND_GOOD : KIND_BAD;
      res.frame_length = count_r[LEN_W-1:0];
    end else if (overflow) begin
      res.kind = KIND_DROP;
    end else if (emit_slot) begin
      res.data         = far_r;
      res.frame_length = count_inc[LEN_W-1:0];
    end else begin
      res.kind = KIND_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      mode_r  <= MODE_NONE;
      flag_r  <= 8'h00;
      count_r <= '0;
      near_r  <= 8'h00;
      far_r   <= 8'h00;
      prime_r <= 2'd0;
      crc_r   <= 16'h0000;
    end else if (consume) begin
      esc_r   <= esc_nxt;
      mode_r  <= mode_nxt;
      flag_r  <= flag_nxt;
      count_r <= count_nxt;
      near_r  <= near_nxt;
      far_r   <= far_nxt;
      prime_r <= prime_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

>>> rtl/core/efr_out_reg.sv
// ----------------------------------------------------------------------------
// efr_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module efr_out_reg import efr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res,
  output logic    can_load
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    priority if (load) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/core/escaped_frame_receiver_crc.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc
// Byte-stuffed frame receiver with crc-16 check (poly 0x1021, init 0).
//
// Input channel in_valid/in_ready/in_rx_byte carries raw line bytes, one
// request per byte. 0xE5 escapes the next byte: escape then 0x00 is a literal
// 0xE5, escape then 0xE5 is again an escape, escape then any other byte is
// a frame boundary that closes an open frame (good/bad crc result) and, for
// bytes 0x80 and up, opens a new frame with that byte as flag. Result channel
// out_valid/out_ready carries kind, data, frame_flag and frame_length;
// payload bytes come out two bytes late, so the trailing crc is never
// emitted. Bytes that give no result are absorbed silently.
// Path: an accepted byte waits in the input register and is then decoded
// into the result register, from which its result can be taken.
// Throughput: one byte per cycle; the decode stage consumes a byte whenever
// the result register is empty or being drained in the same cycle.
// Reset (synchronous, active low) empties both registers, closes any frame
// and clears the crc and delay. When the receiver holds out_ready low the
// result register stays full, the input register fills and in_ready falls.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc import efr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [7:0]       out_frame_flag,
  output logic [LEN_W-1:0] out_frame_length
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       can_load;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance = byte_valid && can_load;

  efr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  efr_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .consume   (advance),
    .rx_byte   (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  efr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign out_kind         = out_res.kind;
  assign out_data         = out_res.data;
  assign out_frame_flag   = out_res.frame_flag;
  assign out_frame_length = out_res.frame_length;

endmodule
